// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Screen geometry, command codes, control characters, field widths and the
// cell address helper.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  // field widths on the ports
  localparam int CMD_W      = 2;
  localparam int CH_W       = 8;
  localparam int ATTR_W     = 8;
  localparam int RD_ROW_W   = 5;
  localparam int RD_COL_W   = 7;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int IN_BITS    = CH_W + ATTR_W + RD_ROW_W + RD_COL_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = OUT_COL_W + OUT_ROW_W + CH_W + ATTR_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT_COLOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

  // control characters
  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CH_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CH_W-1:0]   ch;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  // linear store address of a cell
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ===== design/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console with screen store
// Keeps a ROWS x COLUMNS store of {attr, char} cells and a cursor; handles
// plain put (with scroll), colored put (with wrap), clear and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per accepted beat. in_tuser = cmd (0 plain put,
//           1 colored put, 2 clear, 3 read cell); in_tdata carries the
//           character, attribute and the read coordinates.
//   out_* : exactly one result per request: cursor after the request, plus
//           the read cell (zero for every command other than an in-range read).
//   cfg_* : writes default_attr; always ready. Write it only while idle.
// Sequencing (request accept to result valid, receiver ready):
//   ordinary put, carriage return, backspace: EXEC, then the output register
//   read cell: EXEC, RDWAIT (store read), DONE, then the output register
//   clear: EXEC, a FILL pass over all CELLS, DONE
//   put that scrolls: EXEC, SCROLL, FILL of the bottom row, DONE
//   Clear and scroll run through the single store port pair one cell a cycle;
//   the block takes one request at a time (in_tready only when idle), so it
//   takes no new request before the current result is parked.
// Reset: a clearing pass writes blank cells with attribute 15 over all
//   CELLS (2000) entries, one per cycle; in_tready stays low until it ends.
// Stalls: the result waits in an output register; the next request is taken
//   as soon as the current result is parked there.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: ch[7:0], attr[15:8], read_row[20:16], read_col[27:21], zero pad
  input  logic [tcw_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [tcw_pkg::CMD_W-1:0]        in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
  //            cell_attr[27:20], zero pad
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tcw_pkg::ATTR_W-1:0]       cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);

  // sequencer states
  localparam logic [2:0] S_FILL   = 3'd0;  // blanking sweep (reset, clear, bottom row)
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;  // decode and single-cell work
  localparam logic [2:0] S_RDWAIT = 3'd3;  // store read data arriving
  localparam logic [2:0] S_SCROLL = 3'd4;  // move rows up, one cell a cycle
  localparam logic [2:0] S_DONE   = 3'd5;  // wait for the output register

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;

  logic [2:0]                       state_r, state_nxt;
  logic [tcw_pkg::ATTR_W-1:0]       default_attr_r, default_attr_nxt;
  logic [COL_W-1:0]                 cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]                 cur_row_r, cur_row_nxt;

  // latched request
  logic [tcw_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [tcw_pkg::CH_W-1:0]         ch_r, ch_nxt;
  logic [tcw_pkg::ATTR_W-1:0]       attr_r, attr_nxt;
  logic [tcw_pkg::RD_ROW_W-1:0]     rd_row_r, rd_row_nxt;
  logic [tcw_pkg::RD_COL_W-1:0]     rd_col_r, rd_col_nxt;

  // sweep and scroll bookkeeping
  logic [ADDR_W-1:0]                sweep_r, sweep_nxt;
  logic [tcw_pkg::ATTR_W-1:0]       fill_attr_r, fill_attr_nxt;
  logic                             fill_rsp_r, fill_rsp_nxt;
  logic [ADDR_W-1:0]                src_r, src_nxt;
  logic [ADDR_W-1:0]                dst_r, dst_nxt;
  logic                             pend_r, pend_nxt;
  logic                             rd_more_r, rd_more_nxt;

  // result
  logic [tcw_pkg::CH_W-1:0]         cell_char_r, cell_char_nxt;
  logic [tcw_pkg::ATTR_W-1:0]       cell_attr_r, cell_attr_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [tcw_pkg::OUT_COL_W-1:0]    out_col_r, out_col_nxt;
  logic [tcw_pkg::OUT_ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [tcw_pkg::CH_W-1:0]         out_char_r, out_char_nxt;
  logic [tcw_pkg::ATTR_W-1:0]       out_attr_r, out_attr_nxt;

  // store ports
  logic                             ram_we, ram_re;
  logic [ADDR_W-1:0]                ram_waddr, ram_raddr;
  tcw_pkg::cell_t                   ram_wdata;
  logic [tcw_pkg::CELL_W-1:0]       ram_rdata;
  tcw_pkg::cell_t                   rd_cell;

  // put decode
  logic                             plain;
  logic [COL_W:0]                   ncol;
  logic [ROW_W:0]                   nrow;
  logic                             put_we;
  logic [COL_W-1:0]                 wcol;
  tcw_pkg::cell_t                   put_cell;
  logic                             scroll_req;

  // shared address unit
  logic [ROW_W-1:0]                 au_row;
  logic [COL_W-1:0]                 au_col;
  logic [ADDR_W-1:0]                au_addr;
  logic                             rd_ok;
  logic                             slot_free;
  logic                             fin;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_cell   = tcw_pkg::cell_t'(ram_rdata);
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {(tcw_pkg::OUT_TDATA_W - tcw_pkg::OUT_BITS)'(0),
                      out_attr_r, out_char_r, out_row_r, out_col_r};
  assign slot_free = !out_valid_r || out_tready;

  assign rd_ok = (int'(rd_row_r) < tcw_pkg::ROWS) && (int'(rd_col_r) < tcw_pkg::COLUMNS);

  // put: next cursor and the cell written, if any
  always_comb begin
    plain      = (cmd_r == tcw_pkg::CMD_PUT);
    ncol       = {1'b0, cur_col_r};
    nrow       = {1'b0, cur_row_r};
    put_we     = 1'b0;
    wcol       = cur_col_r;
    put_cell   = '{attr: default_attr_r, ch: ch_r};
    scroll_req = 1'b0;
    if (ch_r == tcw_pkg::CH_NEWLINE) begin
      ncol = '0;
      nrow = nrow + 1'b1;
    end else if (ch_r == tcw_pkg::CH_RETURN) begin
      ncol = {1'b0, cur_col_r};
    end else if (plain && (ch_r == tcw_pkg::CH_BACKSPACE)) begin
      if (cur_col_r != '0) begin
        ncol        = ncol - 1'b1;
        wcol        = cur_col_r - 1'b1;
        put_we      = 1'b1;
        put_cell.ch = tcw_pkg::CH_SPACE;
      end
    end else begin
      put_we = 1'b1;
      ncol   = ncol + 1'b1;
      if (!plain) begin
        put_cell.attr = attr_r;
      end
    end
    // wrap at row end
    if (ncol >= (COL_W+1)'(tcw_pkg::COLUMNS)) begin
      ncol = '0;
      nrow = nrow + 1'b1;
    end
    // past the last row: scroll (plain) or back to the top (colored)
    if (nrow >= (ROW_W+1)'(tcw_pkg::ROWS)) begin
      if (plain) begin
        scroll_req = 1'b1;
        nrow       = (ROW_W+1)'(tcw_pkg::ROWS - 1);
      end else begin
        nrow = '0;
      end
    end
  end

  // one row*COLUMNS+col unit, shared by cell read and cell write
  always_comb begin
    if (cmd_r == tcw_pkg::CMD_READ) begin
      au_row = ROW_W'(rd_row_r);
      au_col = COL_W'(rd_col_r);
    end else begin
      au_row = cur_row_r;
      au_col = wcol;
    end
    au_addr = tcw_pkg::cell_addr(au_row, au_col);
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    default_attr_nxt = default_attr_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    cmd_nxt          = cmd_r;
    ch_nxt           = ch_r;
    attr_nxt         = attr_r;
    rd_row_nxt       = rd_row_r;
    rd_col_nxt       = rd_col_r;
    sweep_nxt        = sweep_r;
    fill_attr_nxt    = fill_attr_r;
    fill_rsp_nxt     = fill_rsp_r;
    src_nxt          = src_r;
    dst_nxt          = dst_r;
    pend_nxt         = pend_r;
    rd_more_nxt      = rd_more_r;
    cell_char_nxt    = cell_char_r;
    cell_attr_nxt    = cell_attr_r;
    out_valid_nxt    = out_valid_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    out_char_nxt     = out_char_r;
    out_attr_nxt     = out_attr_r;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = '0;
    fin              = 1'b0;

    if (cfg_valid) begin
      default_attr_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_tuser;
          ch_nxt     = in_tdata[7:0];
          attr_nxt   = in_tdata[15:8];
          rd_row_nxt = in_tdata[20:16];
          rd_col_nxt = in_tdata[27:21];
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        cell_char_nxt = '0;
        cell_attr_nxt = '0;
        case (cmd_r)
          tcw_pkg::CMD_CLEAR: begin
            cur_col_nxt   = '0;
            cur_row_nxt   = '0;
            fill_attr_nxt = default_attr_r;
            fill_rsp_nxt  = 1'b1;
            sweep_nxt     = '0;
            state_nxt     = S_FILL;
          end
          tcw_pkg::CMD_READ: begin
            if (rd_ok) begin
              ram_re    = 1'b1;
              ram_raddr = au_addr;
              state_nxt = S_RDWAIT;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            cur_col_nxt = COL_W'(ncol);
            cur_row_nxt = ROW_W'(nrow);
            ram_we      = put_we;
            ram_waddr   = au_addr;
            ram_wdata   = put_cell;
            if (scroll_req) begin
              src_nxt     = ADDR_W'(tcw_pkg::COLUMNS);
              rd_more_nxt = 1'b1;
              pend_nxt    = 1'b0;
              state_nxt   = S_SCROLL;
            end else begin
              fin = 1'b1;
            end
          end
        endcase
        // short requests go straight to the output register when it is free
        if (fin) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_col_nxt   = tcw_pkg::OUT_COL_W'(cur_col_nxt);
            out_row_nxt   = tcw_pkg::OUT_ROW_W'(cur_row_nxt);
            out_char_nxt  = '0;
            out_attr_nxt  = '0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_RDWAIT: begin
        cell_char_nxt = rd_cell.ch;
        cell_attr_nxt = rd_cell.attr;
        state_nxt     = S_DONE;
      end

      S_SCROLL: begin
        // read cell src, write it one row up in the next cycle
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = rd_cell;
        end
        if (rd_more_r) begin
          ram_re      = 1'b1;
          ram_raddr   = src_r;
          dst_nxt     = src_r - ADDR_W'(tcw_pkg::COLUMNS);
          pend_nxt    = 1'b1;
          src_nxt     = src_r + 1'b1;
          rd_more_nxt = (src_r != ADDR_W'(tcw_pkg::CELLS - 1));
        end else begin
          // last move written this cycle; blank the bottom row next
          pend_nxt      = 1'b0;
          sweep_nxt     = ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
          fill_attr_nxt = default_attr_r;
          fill_rsp_nxt  = 1'b1;
          state_nxt     = S_FILL;
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = '{attr: fill_attr_r, ch: tcw_pkg::CH_SPACE};
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == ADDR_W'(tcw_pkg::CELLS - 1)) begin
          // the pass after reset answers no request
          state_nxt = fill_rsp_r ? S_DONE : S_IDLE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = tcw_pkg::OUT_COL_W'(cur_col_r);
          out_row_nxt   = tcw_pkg::OUT_ROW_W'(cur_row_r);
          out_char_nxt  = cell_char_r;
          out_attr_nxt  = cell_attr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_FILL;
      default_attr_r <= tcw_pkg::DEFAULT_ATTR_RST;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      sweep_r        <= '0;
      fill_attr_r    <= tcw_pkg::DEFAULT_ATTR_RST;
      fill_rsp_r     <= 1'b0;
      pend_r         <= 1'b0;
      rd_more_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      default_attr_r <= default_attr_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      sweep_r        <= sweep_nxt;
      fill_attr_r    <= fill_attr_nxt;
      fill_rsp_r     <= fill_rsp_nxt;
      pend_r         <= pend_nxt;
      rd_more_r      <= rd_more_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ch_r        <= ch_nxt;
    attr_r      <= attr_nxt;
    rd_row_r    <= rd_row_nxt;
    rd_col_r    <= rd_col_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    cell_char_r <= cell_char_nxt;
    cell_attr_r <= cell_attr_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_char_r  <= out_char_nxt;
    out_attr_r  <= out_attr_nxt;
  end

endmodule
